@@ rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the modular exponentiation unit
// ----------------------------------------------------------------------------
package mexp_pkg;

    // default operand width of base, exponent, modulus and result
    localparam int OPERAND_WIDTH_DEF = 31;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_NEXT,
        S_DONE
    } t_state;

    // operation of the shared multiply-reduce unit
    typedef enum logic [1:0] {
        UOP_REDUCE,
        UOP_SQUARE,
        UOP_MULT
    } t_unit_op;

    // commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     acc_one;
        logic     unit_start;
        t_unit_op unit_op;
        logic     unit_step;
        logic     wr_base;
        logic     wr_acc;
        logic     exp_shift;
        logic     out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic exp_zero;
        logic exp_msb;
    } t_status;

endpackage

@@ rtl/mexp_dp.sv @@
// ----------------------------------------------------------------------------
// mexp_dp
// datapath: modulus register, operand registers and the bit-serial
// multiply-reduce unit shared by base reduction, squaring and multiplying
// ----------------------------------------------------------------------------
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [OPERAND_WIDTH-1:0] i_cfg_data,
    input  logic [OPERAND_WIDTH-1:0] i_base_value,
    input  logic [OPERAND_WIDTH-1:0] i_exponent,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic [OPERAND_WIDTH-1:0] o_power_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int XW = OPERAND_WIDTH + 3;

    logic [W-1:0] r_mod;
    logic [W-1:0] r_base;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_prod;
    logic [W-1:0] r_mcand;
    logic [W-1:0] r_mplier;
    logic [W-1:0] r_out;

    logic [W-1:0]  mod_eff;
    logic          mod_is_one;
    logic [XW-1:0] sum_t;
    logic [XW-1:0] diff_1;
    logic [XW-1:0] diff_2;
    logic [W-1:0]  n_prod;

    // modulus of zero behaves as a modulus of one
    assign mod_is_one = (r_mod <= W'(1));
    assign mod_eff    = mod_is_one ? W'(1) : r_mod;

    // one step: 2*prod + (bit ? mcand : 0), below 3*m, then pick the residue
    always_comb begin
        sum_t  = {2'b00, r_prod, 1'b0}
               + (r_mplier[W-1] ? {3'b000, r_mcand} : {XW{1'b0}});
        diff_1 = sum_t - {3'b000, mod_eff};
        diff_2 = sum_t - {2'b00, mod_eff, 1'b0};
        if (!diff_2[XW-1]) begin
            n_prod = diff_2[W-1:0];
        end else if (!diff_1[XW-1]) begin
            n_prod = diff_1[W-1:0];
        end else begin
            n_prod = sum_t[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(1);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base_value;
            r_exp  <= i_exponent;
            r_acc  <= mod_is_one ? W'(0) : W'(1);
        end else begin
            if (i_cmd.acc_one) begin
                r_acc <= W'(1);
            end else if (i_cmd.wr_acc) begin
                r_acc <= n_prod;
            end
            if (i_cmd.wr_base) begin
                r_base <= n_prod;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= {r_exp[W-2:0], 1'b0};
            end
        end

        if (i_cmd.unit_start) begin
            r_prod <= '0;
            case (i_cmd.unit_op)
                UOP_REDUCE: begin
                    r_mcand  <= W'(1);
                    r_mplier <= r_base;
                end
                UOP_SQUARE: begin
                    r_mcand  <= r_acc;
                    r_mplier <= r_acc;
                end
                UOP_MULT: begin
                    r_mcand  <= r_base;
                    r_mplier <= r_acc;
                end
                default: begin
                    r_mcand  <= r_acc;
                    r_mplier <= r_acc;
                end
            endcase
        end else if (i_cmd.unit_step) begin
            r_prod   <= n_prod;
            r_mplier <= {r_mplier[W-2:0], 1'b0};
        end

        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_msb  = r_exp[W-1];
    assign o_power_result    = r_out;

endmodule

@@ rtl/mexp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mexp_ctrl
// controller: sequences base reduction and the square-and-multiply scan
// ----------------------------------------------------------------------------
module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    t_state           r_state;
    t_state           n_state;
    t_unit_op         r_op;
    t_unit_op         n_op;
    logic [CNT_W-1:0] r_step_cnt;
    logic [CNT_W-1:0] n_step_cnt;
    logic [CNT_W-1:0] r_bit_cnt;
    logic [CNT_W-1:0] n_bit_cnt;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= UOP_REDUCE;
            r_step_cnt  <= '0;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_step_cnt  <= n_step_cnt;
            r_bit_cnt   <= n_bit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_step_cnt = r_step_cnt;
        n_bit_cnt  = r_bit_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.exp_zero) begin
                    o_cmd.acc_one = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.unit_start = 1'b1;
                    o_cmd.unit_op    = UOP_REDUCE;
                    n_op             = UOP_REDUCE;
                    n_step_cnt       = CNT_W'(OPERAND_WIDTH - 1);
                    n_bit_cnt        = CNT_W'(OPERAND_WIDTH - 1);
                    n_state          = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.unit_step = 1'b1;
                if (r_step_cnt == '0) begin
                    // last step writes the residue to its target
                    if (r_op == UOP_REDUCE) begin
                        o_cmd.wr_base = 1'b1;
                    end else begin
                        o_cmd.wr_acc = 1'b1;
                    end
                    n_state = S_NEXT;
                end else begin
                    n_step_cnt = r_step_cnt - CNT_W'(1);
                end
            end
            S_NEXT: begin
                n_step_cnt = CNT_W'(OPERAND_WIDTH - 1);
                if (r_op == UOP_SQUARE && i_status.exp_msb) begin
                    o_cmd.unit_start = 1'b1;
                    o_cmd.unit_op    = UOP_MULT;
                    n_op             = UOP_MULT;
                    n_state          = S_RUN;
                end else if (r_op != UOP_REDUCE && r_bit_cnt == '0) begin
                    o_cmd.exp_shift = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    // next exponent bit, or the first one after base reduction
                    if (r_op != UOP_REDUCE) begin
                        o_cmd.exp_shift = 1'b1;
                        n_bit_cnt       = r_bit_cnt - CNT_W'(1);
                    end
                    o_cmd.unit_start = 1'b1;
                    o_cmd.unit_op    = UOP_SQUARE;
                    n_op             = UOP_SQUARE;
                    n_state          = S_RUN;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && i_out_stall) || o_cmd.out_load;
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base raised to an exponent modulo a configured modulus, square-and-multiply
// ----------------------------------------------------------------------------
// usage:
//   write the modulus through i_cfg_we / i_cfg_data while the block is idle;
//   a modulus of zero acts as one. an item (base, exponent) is taken when
//   i_in_valid is high and o_in_stall is low; one result item follows on
//   o_out_valid / o_power_result and is taken when i_out_stall is low.
// sequence and throughput (W = OPERAND_WIDTH, k = set bits of the exponent):
//   zero exponent: no product is formed; result 1 goes to the output register.
//   otherwise one base reduction, then W squarings and k multiplies. the
//   one multiply-reduce unit takes one multiplier bit a cycle, all W bits
//   per modular product, and is shared by the base reduction, every
//   squaring and every multiply, so it sets the rate.
//   items are worked one at a time; o_in_stall is low only while idle.
// reset (i_rst_n, synchronous, active low) sets the modulus to 1, empties
//   the output register and returns the controller to idle.
// a stalled result holds in the output register; the next item can be
//   taken meanwhile, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration: modulus
    input  logic                     i_cfg_we,
    input  logic [OPERAND_WIDTH-1:0] i_cfg_data,
    // input item channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OPERAND_WIDTH-1:0] i_base_value,
    input  logic [OPERAND_WIDTH-1:0] i_exponent,
    // result item channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [OPERAND_WIDTH-1:0] o_power_result
);

    t_cmd    cmd;
    t_status status;

    // sequencer: base reduction, then one square per exponent bit and a
    // multiply for each set bit, msb first
    mexp_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // registers and the bit-serial multiply-reduce unit
    mexp_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_power_result (o_power_result)
    );

endmodule

@@ tb/sv/modular_exponentiation_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_test
// self-checking bench for the square-and-multiply modular exponentiation unit
// ----------------------------------------------------------------------------
// the modulus is stepped through a list of settings, from zero and one up to
// the largest value. the first three settings get a few hand-picked items;
// every setting gets random ones. both handshakes idle and stall at random
// outside the quiet phases. a scoreboard predicts every result from the
// accepted item and the current modulus and compares it with the block's.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_test;
    import mexp_pkg::*;

    localparam int W = OPERAND_WIDTH_DEF;
    localparam bit [W-1:0] OPERAND_MAX = '1;
    // 290 items plus long gaps and stalls stay well below this
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_PER_PHASE = 22;
    localparam int NUM_PHASES = 12;

    // expected power results, computed when an item is accepted
    class mod_power_board;
        bit [W-1:0] modulus;
        bit [W-1:0] pending_powers[$];
        int fail_count;

        function new();
            modulus = 1;
            fail_count = 0;
        endfunction

        function void set_modulus(bit [W-1:0] m);
            modulus = m;
        endfunction

        // right-to-left square-and-multiply, products fit in 62 bits
        function bit [W-1:0] mod_pow(bit [W-1:0] b, bit [W-1:0] e);
            longint unsigned m;
            longint unsigned sq;
            longint unsigned acc;
            m = (modulus == 0) ? 64'd1 : 64'(modulus);
            if (e == 0) return W'(1);
            sq = 64'(b) % m;
            acc = 64'd1 % m;
            for (int i = 0; i < W; i++) begin
                if (e[i]) acc = (acc * sq) % m;
                sq = (sq * sq) % m;
            end
            return acc[W-1:0];
        endfunction

        function void note_input(bit [W-1:0] b, bit [W-1:0] e);
            pending_powers.push_back(mod_pow(b, e));
        endfunction

        function void check_result(bit [W-1:0] actual);
            bit [W-1:0] want;
            if (pending_powers.size() == 0) begin
                $error("power_result: no item outstanding, actual %0d", actual);
                fail_count++;
            end else begin
                want = pending_powers.pop_front();
                if (want != actual) begin
                    $error("power_result: expected %0d, actual %0d", want, actual);
                    fail_count++;
                end
            end
        endfunction

        function int pending();
            return pending_powers.size();
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [W-1:0]   i_cfg_data = '0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    logic [W-1:0]   i_base_value = '0;
    logic [W-1:0]   i_exponent = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    logic [W-1:0]   o_power_result;

    mod_power_board power_board = new();

    // phases with no idling on the sender or no stalls on the receiver
    bit             quiet_in = 1'b0;
    bit             quiet_out = 1'b0;
    int             stall_left = 0;
    int             cycle_count = 0;
    bit [W-1:0]     phase_moduli[NUM_PHASES];

    modular_exponentiation_unit #(
        .OPERAND_WIDTH (W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_result (o_power_result)
    );

    always #1 i_clk = ~i_clk;

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // both handshakes seen at the rising edge; the result is checked first
    // so a new item never stands in for an older missing one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) power_board.check_result(o_power_result);
            if (i_in_valid && !o_in_stall) power_board.note_input(i_base_value, i_exponent);
        end
    end

    // receiver stall: runs of random length, mostly short, now and then long
    always @(negedge i_clk) begin
        if (quiet_out) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    i_out_stall <= 1'b0;
                    stall_left <= $urandom_range(0, 4);
                end
                9: begin
                    i_out_stall <= 1'b1;
                    stall_left <= $urandom_range(20, 80);
                end
                default: begin
                    i_out_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet_in) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_item(input bit [W-1:0] b, input bit [W-1:0] e);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_base_value = b;
        i_exponent = e;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // sender stops until every expected result is back, then idles before returning
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (power_board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_modulus(input bit [W-1:0] m);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = m;
        power_board.set_modulus(m);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_data = W'($urandom());
    endtask

    // random item biased toward edges: zero, all ones, modulus - 1,
    // small values and single-bit exponents
    task automatic random_items(input int count);
        bit [W-1:0] b;
        bit [W-1:0] e;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: b = '0;
                1: b = OPERAND_MAX;
                2: b = (power_board.modulus == 0) ? '0 : power_board.modulus - 1'b1;
                3: b = W'($urandom_range(0, 255));
                default: b = W'($urandom());
            endcase
            case ($urandom_range(0, 9))
                0: e = '0;
                1: e = OPERAND_MAX;
                2: e = W'(1);
                3, 4: e = W'($urandom_range(1, 255));
                5: e = W'(1) << $urandom_range(0, W - 1);
                default: e = W'($urandom());
            endcase
            send_item(b, e);
        end
    endtask

    initial begin
        phase_moduli = '{31'd0, 31'd2147483647, 31'd13, 31'd2, 31'd3, 31'd97,
                         31'd65537, 31'd1073741824, 31'd2147483646, 31'd0,
                         31'd0, 31'd1};
        phase_moduli[9] = W'($urandom_range(2, 2147483647));
        phase_moduli[10] = W'($urandom_range(1 << 24, 2147483647));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(posedge i_clk);

        // modulus left at its reset value of one: zero exponent still gives 1
        send_item(31'd5, 31'd0);
        send_item(31'd5, 31'd7);
        send_item(OPERAND_MAX, OPERAND_MAX);
        send_item(31'd0, 31'd0);
        random_items(6);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            quiet_in = (p % 4 == 2);
            quiet_out = (p % 4 == 3);
            write_modulus(phase_moduli[p]);
            if (p == 0) begin
                // modulus of zero acts as one
                send_item(31'd12, 31'd3);
                send_item(31'd3, 31'd0);
                send_item(OPERAND_MAX, OPERAND_MAX);
            end else if (p == 1) begin
                // largest modulus, all register bits set
                send_item(31'd0, 31'd0);
                send_item(31'd0, 31'd5);
                send_item(OPERAND_MAX, 31'd1);
                send_item(OPERAND_MAX - 1'b1, OPERAND_MAX);
                send_item(31'd2, 31'd30);
                send_item(31'd2, 31'd31);
                send_item(31'd1, OPERAND_MAX);
                send_item(31'd12345, 31'd1);
            end else if (p == 2) begin
                // base at or above the modulus is reduced first
                send_item(31'd100, 31'd1);
                send_item(31'd13, 31'd5);
                send_item(31'd2, 31'd12);
                send_item(OPERAND_MAX, OPERAND_MAX);
                send_item(31'd7, 31'd0);
            end
            random_items(RANDOM_PER_PHASE);
            drain();
        end

        quiet_in = 1'b0;
        quiet_out = 1'b0;
        // room for any stray result after the last one
        repeat (2100) @(posedge i_clk);
        if (power_board.fail_count == 0 && power_board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
